[hdl/ffc_pkg.sv]
`default_nettype none

package ffc_pkg;

	localparam int unsigned MAX_STEPS = 16;
	localparam int unsigned ADDR_W = $clog2(MAX_STEPS);
	localparam int unsigned PTR_W = $clog2(MAX_STEPS + 1);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam ptr_t MAX_PTR = ptr_t'(MAX_STEPS);

	localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
	localparam logic [31:0] MS_PER_SECOND = 32'd1000;

	localparam logic [2:0] KIND_TICK = 3'd0;
	localparam logic [2:0] KIND_LOAD = 3'd1;
	localparam logic [2:0] KIND_FERM = 3'd2;
	localparam logic [2:0] KIND_FILT = 3'd3;
	localparam logic [2:0] KIND_STOP = 3'd4;

	localparam logic [1:0] RUN_IDLE = 2'd0;
	localparam logic [1:0] RUN_FERM = 2'd1;
	localparam logic [1:0] RUN_FILT = 2'd2;

	localparam logic [2:0] CFG_HYSTERESIS = 3'd0;
	localparam logic [2:0] CFG_ALARM_LIMIT = 3'd1;
	localparam logic [2:0] CFG_PUMP_HOLD = 3'd2;
	localparam logic [2:0] CFG_PUMP_RUN = 3'd3;
	localparam logic [2:0] CFG_PUMP_REST = 3'd4;
	localparam logic [2:0] CFG_FILT_SETPOINT = 3'd5;

	typedef enum logic [2:0] {
		MODE_OFF = 3'b001,
		MODE_FERM = 3'b010,
		MODE_FILT = 3'b100
	} mode_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] now_ms;
		logic signed [11:0] temperature;
		logic [3:0] step_index;
		logic signed [11:0] step_target;
		logic [10:0] step_hold_hours;
		logic [4:0] step_count;
		logic [22:0] run_seconds;
	} in_item_t;

	typedef struct packed {
		logic heater_active;
		logic pump_active;
		logic alarm_latched;
		logic [1:0] run_mode;
		logic [4:0] step_number;
		logic signed [11:0] active_setpoint;
	} out_item_t;

	typedef struct packed {
		logic [8:0] hysteresis;
		logic signed [11:0] alarm_limit;
		logic [31:0] pump_hold_after_heat;
		logic [31:0] pump_run_time;
		logic [31:0] pump_rest_time;
		logic signed [11:0] filtration_setpoint;
	} cfg_t;

	typedef struct packed {
		logic signed [11:0] target;
		logic [10:0] hours;
	} profile_entry_t;

	typedef struct packed {
		logic we;
		addr_t addr;
		profile_entry_t entry;
	} prof_wr_t;

	typedef struct packed {
		profile_entry_t cur;
		logic signed [11:0] next_target;
		logic signed [11:0] first_target;
	} prof_rd_t;

endpackage

`default_nettype wire

[hdl/ffc_ram.sv]
`default_nettype none

module ffc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

[hdl/ffc_profile.sv]
`default_nettype none

module ffc_profile (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ffc_pkg::prof_wr_t wr,
	input  wire ffc_pkg::addr_t    raddr,
	output ffc_pkg::prof_rd_t      rd
);

	localparam int unsigned ENTRY_W = $bits(ffc_pkg::profile_entry_t);

	ffc_pkg::addr_t raddr_next;
	logic [ENTRY_W-1:0] ram_a;
	logic [ENTRY_W-1:0] ram_b;
	logic byp_a_q;
	logic byp_b_q;
	ffc_pkg::profile_entry_t byp_data_q;
	logic signed [11:0] first_target_q;
	ffc_pkg::profile_entry_t entry_b;

	assign raddr_next = raddr + ffc_pkg::addr_t'(1);

	ffc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ffc_pkg::MAX_STEPS)
	) u_ram (
		.clk     (clk),
		.we      (wr.we),
		.waddr   (wr.addr),
		.wdata   (wr.entry),
		.raddr_a (raddr),
		.rdata_a (ram_a),
		.raddr_b (raddr_next),
		.rdata_b (ram_b)
	);

	// A write to the entry being read in the same cycle is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_a_q <= 1'b0;
			byp_b_q <= 1'b0;
		end else begin
			byp_a_q <= wr.we && (wr.addr == raddr);
			byp_b_q <= wr.we && (wr.addr == raddr_next);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= wr.entry;
		if (wr.we && (wr.addr == '0)) begin
			first_target_q <= wr.entry.target;
		end
	end

	assign entry_b = ffc_pkg::profile_entry_t'(ram_b);

	assign rd.cur = byp_a_q ? byp_data_q : ffc_pkg::profile_entry_t'(ram_a);
	assign rd.next_target = byp_b_q ? byp_data_q.target : entry_b.target;
	assign rd.first_target = first_target_q;

endmodule

`default_nettype wire

[hdl/ffc_core.sv]
`default_nettype none

module ffc_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire ffc_pkg::in_item_t  item,
	input  wire ffc_pkg::cfg_t      cfg,
	input  wire ffc_pkg::prof_rd_t  rd,
	output ffc_pkg::prof_wr_t       wr,
	output ffc_pkg::addr_t          raddr,
	output ffc_pkg::out_item_t      result
);

	ffc_pkg::mode_t mode_q, mode_nx;
	ffc_pkg::ptr_t ptr_q, ptr_nx, ptr_d;
	ffc_pkg::ptr_t total_q, total_nx;
	ffc_pkg::ptr_t cnt_sat;
	logic signed [11:0] sp_q, sp_nx;
	logic [31:0] started_q, started_nx;
	logic [31:0] ends_q, ends_nx;
	logic [31:0] cyc_q, cyc_nx;
	logic run_q, run_nx;
	logic [31:0] hea_q, hea_nx;
	logic was_on_q, was_on_nx;
	logic heat_q, heat_nx;
	logic pump_q, pump_nx;
	logic alarm_q, alarm_nx;
	logic stop_c;
	logic safe_c;
	logic [32:0] hold_lim;
	logic [31:0] step_el;
	logic [31:0] cyc_el;
	logic [31:0] ends_calc;
	logic over_temp;

	function automatic logic therm(input logic signed [11:0] t, input logic signed [11:0] sp,
			input logic [8:0] h, input logic cur);
		logic signed [13:0] hx;
		logic signed [13:0] lo;
		logic signed [13:0] hi;
		logic signed [13:0] tx;
		logic res;
		hx = signed'({5'd0, h});
		lo = 14'(sp) - hx;
		hi = 14'(sp) + hx;
		tx = 14'(t);
		res = cur;
		if (tx < lo) begin
			res = 1'b1;
		end else if (tx > hi) begin
			res = 1'b0;
		end
		return res;
	endfunction

	assign hold_lim = 33'(rd.cur.hours) * 33'(ffc_pkg::MS_PER_HOUR);
	assign step_el = item.now_ms - started_q;
	assign cyc_el = item.now_ms - cyc_q;
	assign ends_calc = item.now_ms + 32'(32'(item.run_seconds) * ffc_pkg::MS_PER_SECOND);
	assign over_temp = item.temperature > cfg.alarm_limit;
	assign cnt_sat = (item.step_count > ffc_pkg::MAX_PTR) ? ffc_pkg::MAX_PTR : item.step_count;

	always_comb begin
		mode_nx = mode_q;
		ptr_nx = ptr_q;
		total_nx = total_q;
		sp_nx = sp_q;
		started_nx = started_q;
		ends_nx = ends_q;
		cyc_nx = cyc_q;
		run_nx = run_q;
		hea_nx = hea_q;
		was_on_nx = was_on_q;
		heat_nx = heat_q;
		pump_nx = pump_q;
		alarm_nx = alarm_q;
		stop_c = 1'b0;
		safe_c = 1'b0;
		case (item.kind)
			ffc_pkg::KIND_TICK: begin
				if (mode_q == ffc_pkg::MODE_FERM) begin
					if (ptr_q >= total_q || ptr_q >= ffc_pkg::MAX_PTR) begin
						stop_c = 1'b1;
					end else begin
						sp_nx = rd.cur.target;
						heat_nx = therm(item.temperature, rd.cur.target, cfg.hysteresis, heat_q);
						if (alarm_q) begin
							pump_nx = 1'b1;
						end else if (heat_nx) begin
							pump_nx = 1'b1;
							was_on_nx = 1'b1;
						end else begin
							if (was_on_q) begin
								hea_nx = item.now_ms;
								was_on_nx = 1'b0;
							end
							pump_nx = 32'(item.now_ms - hea_nx) < cfg.pump_hold_after_heat;
						end
						if ({1'b0, step_el} >= hold_lim) begin
							ptr_nx = ptr_q + ffc_pkg::ptr_t'(1);
							if (ptr_nx < total_q && ptr_nx < ffc_pkg::MAX_PTR) begin
								started_nx = item.now_ms;
								sp_nx = rd.next_target;
							end else begin
								stop_c = 1'b1;
							end
						end
						safe_c = 1'b1;
					end
				end else if (mode_q == ffc_pkg::MODE_FILT) begin
					heat_nx = therm(item.temperature, cfg.filtration_setpoint, cfg.hysteresis,
						heat_q);
					if (alarm_q) begin
						pump_nx = 1'b1;
					end else if (run_q) begin
						if (cyc_el >= cfg.pump_run_time) begin
							pump_nx = 1'b0;
							run_nx = 1'b0;
							cyc_nx = item.now_ms;
						end
					end else if (cyc_el >= cfg.pump_rest_time) begin
						pump_nx = 1'b1;
						run_nx = 1'b1;
						cyc_nx = item.now_ms;
					end
					if (item.now_ms >= ends_q) begin
						stop_c = 1'b1;
					end
					safe_c = 1'b1;
				end
			end
			ffc_pkg::KIND_FERM: begin
				if (item.step_count != '0) begin
					mode_nx = ffc_pkg::MODE_FERM;
					total_nx = cnt_sat;
					ptr_nx = '0;
					started_nx = item.now_ms;
					sp_nx = rd.first_target;
					hea_nx = item.now_ms;
					was_on_nx = 1'b0;
				end
			end
			ffc_pkg::KIND_FILT: begin
				mode_nx = ffc_pkg::MODE_FILT;
				ends_nx = ends_calc;
				pump_nx = 1'b1;
				heat_nx = 1'b0;
				cyc_nx = item.now_ms;
				run_nx = 1'b1;
			end
			ffc_pkg::KIND_STOP: begin
				stop_c = 1'b1;
			end
			default: begin
			end
		endcase
		if (stop_c) begin
			mode_nx = ffc_pkg::MODE_OFF;
			heat_nx = 1'b0;
			pump_nx = 1'b0;
			alarm_nx = 1'b0;
			was_on_nx = 1'b0;
		end
		if (safe_c && over_temp) begin
			alarm_nx = 1'b1;
			heat_nx = 1'b0;
			pump_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ffc_pkg::MODE_OFF;
			ptr_q <= '0;
			total_q <= '0;
			sp_q <= '0;
			started_q <= '0;
			ends_q <= '0;
			cyc_q <= '0;
			run_q <= 1'b0;
			hea_q <= '0;
			was_on_q <= 1'b0;
			heat_q <= 1'b0;
			pump_q <= 1'b0;
			alarm_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_nx;
			ptr_q <= ptr_nx;
			total_q <= total_nx;
			sp_q <= sp_nx;
			started_q <= started_nx;
			ends_q <= ends_nx;
			cyc_q <= cyc_nx;
			run_q <= run_nx;
			hea_q <= hea_nx;
			was_on_q <= was_on_nx;
			heat_q <= heat_nx;
			pump_q <= pump_nx;
			alarm_q <= alarm_nx;
		end
	end

	// The profile is read ahead at the step the next item will see.
	assign ptr_d = fire ? ptr_nx : ptr_q;
	assign raddr = ptr_d[ffc_pkg::ADDR_W-1:0];

	assign wr.we = fire && (item.kind == ffc_pkg::KIND_LOAD);
	assign wr.addr = item.step_index;
	assign wr.entry.target = item.step_target;
	assign wr.entry.hours = item.step_hold_hours;

	always_comb begin
		result.heater_active = heat_nx;
		result.pump_active = pump_nx;
		result.alarm_latched = alarm_nx;
		result.step_number = ptr_nx;
		result.active_setpoint = sp_nx;
		case (mode_nx)
			ffc_pkg::MODE_FERM: result.run_mode = ffc_pkg::RUN_FERM;
			ffc_pkg::MODE_FILT: result.run_mode = ffc_pkg::RUN_FILT;
			default: result.run_mode = ffc_pkg::RUN_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[hdl/ferment_filter_temperature_controller.sv]
`default_nettype none

// Fermentation and filtration temperature controller. Each input item carries a command
// (tick, load profile step, start fermentation, start filtration, stop), a millisecond
// timestamp and a temperature; each item yields exactly one result item with the heater,
// pump and alarm drives, the run mode, the current step and the active setpoint after that
// item. The block takes one item per clock cycle unless the output stalls: the item is
// registered, its whole state update is done in one pass of logic, and the result is
// registered. The one-pass update is what allows this rate; the sixteen-entry profile sits
// in a small RAM whose registered read is aimed at the step the next item will use, with
// writes forwarded. Profile entries must be loaded before a fermentation run reads them.
// Configuration registers must be written through the plain write port while no item is in
// flight; the block itself does not enforce this.
module ferment_filter_temperature_controller (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ffc_pkg::in_item_t   in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ffc_pkg::out_item_t       out_item,
	input  wire logic                cfg_wen,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_wdata
);

	logic valid_s1;
	ffc_pkg::in_item_t item_s1;
	logic out_valid_q;
	ffc_pkg::out_item_t out_item_q;
	ffc_pkg::cfg_t cfg_q;
	logic fire;
	ffc_pkg::prof_wr_t prof_wr;
	ffc_pkg::prof_rd_t prof_rd;
	ffc_pkg::addr_t prof_raddr;
	ffc_pkg::out_item_t result;

	assign fire = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hysteresis <= 9'd5;
			cfg_q.alarm_limit <= 12'sd480;
			cfg_q.pump_hold_after_heat <= 32'd600000;
			cfg_q.pump_run_time <= 32'd60000;
			cfg_q.pump_rest_time <= 32'd180000;
			cfg_q.filtration_setpoint <= 12'sd1216;
		end else if (cfg_wen) begin
			case (cfg_index)
				ffc_pkg::CFG_HYSTERESIS: cfg_q.hysteresis <= cfg_wdata[8:0];
				ffc_pkg::CFG_ALARM_LIMIT: cfg_q.alarm_limit <= signed'(cfg_wdata[11:0]);
				ffc_pkg::CFG_PUMP_HOLD: cfg_q.pump_hold_after_heat <= cfg_wdata;
				ffc_pkg::CFG_PUMP_RUN: cfg_q.pump_run_time <= cfg_wdata;
				ffc_pkg::CFG_PUMP_REST: cfg_q.pump_rest_time <= cfg_wdata;
				ffc_pkg::CFG_FILT_SETPOINT: cfg_q.filtration_setpoint <= signed'(cfg_wdata[11:0]);
				default: begin
				end
			endcase
		end
	end

	ffc_profile u_profile (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (prof_wr),
		.raddr  (prof_raddr),
		.rd     (prof_rd)
	);

	ffc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.rd     (prof_rd),
		.wr     (prof_wr),
		.raddr  (prof_raddr),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

`ifndef SYNTH
	a_alarm_forces_pump: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.alarm_latched |-> out_item.pump_active)
		else $error("Latched alarm without the pump running.");

	a_idle_heater_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.run_mode == ffc_pkg::RUN_IDLE) |-> !out_item.heater_active)
		else $error("Heater on while the controller is idle.");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.step_number <= ffc_pkg::MAX_PTR))
		else $error("Step number beyond the profile length.");
`endif

endmodule

`default_nettype wire

[verif/ferment_filter_temperature_controller_tb.sv]
`default_nettype none

module ferment_filter_temperature_controller_tb;
	import ffc_pkg::*;

	localparam int QUIET_LIMIT = 3000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_wen;
	logic [2:0] cfg_index;
	logic [31:0] cfg_wdata;

	ferment_filter_temperature_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	cfg_t ctl_cfg;
	logic [1:0] st_mode;
	logic [PTR_W-1:0] st_ptr;
	logic [PTR_W-1:0] st_total;
	logic signed [11:0] st_setpoint;
	logic [31:0] st_step_t0;
	logic [31:0] st_filt_end;
	logic [31:0] st_cycle_t0;
	logic st_cycle_run;
	logic [31:0] st_heat_end;
	logic st_heat_was_on;
	logic st_heater;
	logic st_pump;
	logic st_alarm;
	logic signed [11:0] prof_target [MAX_STEPS];
	logic [10:0] prof_hours [MAX_STEPS];
	logic [MAX_STEPS-1:0] profile_written;

	out_item_t predicted_outputs [$];
	int unsigned error_count;
	int unsigned items_sent;
	int unsigned quiet_cycles;
	logic [31:0] clock_ms;
	bit idling;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void reset_controller_model();
		ctl_cfg.hysteresis = 9'd5;
		ctl_cfg.alarm_limit = 12'sd480;
		ctl_cfg.pump_hold_after_heat = 32'd600000;
		ctl_cfg.pump_run_time = 32'd60000;
		ctl_cfg.pump_rest_time = 32'd180000;
		ctl_cfg.filtration_setpoint = 12'sd1216;
		st_mode = RUN_IDLE;
		st_ptr = '0;
		st_total = '0;
		st_setpoint = '0;
		st_step_t0 = '0;
		st_filt_end = '0;
		st_cycle_t0 = '0;
		st_cycle_run = 1'b0;
		st_heat_end = '0;
		st_heat_was_on = 1'b0;
		st_heater = 1'b0;
		st_pump = 1'b0;
		st_alarm = 1'b0;
		profile_written = '0;
	endfunction

	function automatic void halt_run();
		st_mode = RUN_IDLE;
		st_heater = 1'b0;
		st_pump = 1'b0;
		st_alarm = 1'b0;
		st_heat_was_on = 1'b0;
	endfunction

	function automatic void run_thermostat(int temp, int set);
		int hyst;
		hyst = int'(ctl_cfg.hysteresis);
		if (temp < set - hyst)
			st_heater = 1'b1;
		else if (temp > set + hyst)
			st_heater = 1'b0;
	endfunction

	function automatic void check_overheat(int temp);
		if (temp > int'(ctl_cfg.alarm_limit)) begin
			st_alarm = 1'b1;
			st_heater = 1'b0;
			st_pump = 1'b1;
		end
	endfunction

	function automatic void fermentation_tick(logic [31:0] now, int temp);
		logic [63:0] hold_ms;
		logic [31:0] elapsed;
		if (st_ptr >= st_total || st_ptr >= MAX_PTR) begin
			halt_run();
			return;
		end
		st_setpoint = prof_target[st_ptr[ADDR_W-1:0]];
		run_thermostat(temp, int'(st_setpoint));
		if (st_alarm) begin
			st_pump = 1'b1;
		end else if (st_heater) begin
			st_pump = 1'b1;
			st_heat_was_on = 1'b1;
		end else begin
			if (st_heat_was_on) begin
				st_heat_end = now;
				st_heat_was_on = 1'b0;
			end
			st_pump = (now - st_heat_end) < ctl_cfg.pump_hold_after_heat;
		end
		hold_ms = 64'(prof_hours[st_ptr[ADDR_W-1:0]]) * 64'(MS_PER_HOUR);
		elapsed = now - st_step_t0;
		if (64'(elapsed) >= hold_ms) begin
			st_ptr = st_ptr + ptr_t'(1);
			if (st_ptr < st_total && st_ptr < MAX_PTR) begin
				st_step_t0 = now;
				st_setpoint = prof_target[st_ptr[ADDR_W-1:0]];
			end else begin
				halt_run();
			end
		end
		check_overheat(temp);
	endfunction

	function automatic void filtration_tick(logic [31:0] now, int temp);
		logic [31:0] elapsed;
		run_thermostat(temp, int'(ctl_cfg.filtration_setpoint));
		elapsed = now - st_cycle_t0;
		if (st_alarm) begin
			st_pump = 1'b1;
		end else if (st_cycle_run) begin
			if (elapsed >= ctl_cfg.pump_run_time) begin
				st_pump = 1'b0;
				st_cycle_run = 1'b0;
				st_cycle_t0 = now;
			end
		end else if (elapsed >= ctl_cfg.pump_rest_time) begin
			st_pump = 1'b1;
			st_cycle_run = 1'b1;
			st_cycle_t0 = now;
		end
		if (now >= st_filt_end)
			halt_run();
		check_overheat(temp);
	endfunction

	function automatic out_item_t advance_controller(in_item_t it);
		out_item_t res;
		int temp;
		logic [PTR_W-1:0] count;
		temp = int'(it.temperature);
		case (it.kind)
			KIND_TICK: begin
				if (st_mode == RUN_FERM)
					fermentation_tick(it.now_ms, temp);
				else if (st_mode == RUN_FILT)
					filtration_tick(it.now_ms, temp);
			end
			KIND_LOAD: begin
				prof_target[it.step_index] = it.step_target;
				prof_hours[it.step_index] = it.step_hold_hours;
			end
			KIND_FERM: begin
				if (it.step_count != '0) begin
					count = it.step_count;
					if (count > MAX_PTR)
						count = MAX_PTR;
					st_mode = RUN_FERM;
					st_total = count;
					st_ptr = '0;
					st_step_t0 = it.now_ms;
					st_setpoint = prof_target[0];
					st_heat_end = it.now_ms;
					st_heat_was_on = 1'b0;
				end
			end
			KIND_FILT: begin
				st_mode = RUN_FILT;
				st_filt_end = 32'(64'(it.now_ms) + 64'(it.run_seconds) * 64'(MS_PER_SECOND));
				st_pump = 1'b1;
				st_heater = 1'b0;
				st_cycle_t0 = it.now_ms;
				st_cycle_run = 1'b1;
			end
			KIND_STOP: begin
				halt_run();
			end
			default: begin
			end
		endcase
		res.heater_active = st_heater;
		res.pump_active = st_pump;
		res.alarm_latched = st_alarm;
		res.run_mode = st_mode;
		res.step_number = st_ptr;
		res.active_setpoint = st_setpoint;
		return res;
	endfunction

	task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= 40)
			$display("ERROR %s: got %0h, predicted %0h at %0t", what, got, want, $time);
	endtask

	task automatic compare_outputs(out_item_t got, out_item_t want);
		if (got.heater_active !== want.heater_active)
			report_error("heater_active", 32'(got.heater_active), 32'(want.heater_active));
		if (got.pump_active !== want.pump_active)
			report_error("pump_active", 32'(got.pump_active), 32'(want.pump_active));
		if (got.alarm_latched !== want.alarm_latched)
			report_error("alarm_latched", 32'(got.alarm_latched), 32'(want.alarm_latched));
		if (got.run_mode !== want.run_mode)
			report_error("run_mode", 32'(got.run_mode), 32'(want.run_mode));
		if (got.step_number !== want.step_number)
			report_error("step_number", 32'(got.step_number), 32'(want.step_number));
		if (got.active_setpoint !== want.active_setpoint)
			report_error("active_setpoint", 32'(got.active_setpoint),
				32'(want.active_setpoint));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_outputs.size() == 0)
				report_error("result with nothing pending", 32'(out_item), '0);
			else
				compare_outputs(out_item, predicted_outputs.pop_front());
		end
	end

	always @(posedge clk) begin
		out_stall <= idling && ($urandom_range(0, 99) < 11);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_item(in_item_t it);
		int loaded;
		if (it.kind == KIND_FERM) begin
			loaded = 0;
			while (loaded < MAX_STEPS && profile_written[loaded])
				loaded++;
			if (it.step_count > loaded)
				it.step_count = 5'(loaded);
		end
		if (idling && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.kind == KIND_LOAD)
			profile_written[it.step_index] = 1'b1;
		predicted_outputs.push_back(advance_controller(it));
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(cfg_t c);
		logic [31:0] vals [6];
		logic [2:0] regs [6];
		vals = '{32'(c.hysteresis), 32'(c.alarm_limit), c.pump_hold_after_heat,
			c.pump_run_time, c.pump_rest_time, 32'(c.filtration_setpoint)};
		regs = '{CFG_HYSTERESIS, CFG_ALARM_LIMIT, CFG_PUMP_HOLD, CFG_PUMP_RUN,
			CFG_PUMP_REST, CFG_FILT_SETPOINT};
		for (int i = 0; i < 6; i++) begin
			cfg_wen <= 1'b1;
			cfg_index <= regs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
		ctl_cfg = c;
	endtask

	function automatic logic signed [11:0] any_temp();
		return 12'(int'($urandom_range(0, 2880)) - 880);
	endfunction

	function automatic logic signed [11:0] temp_near(int set);
		int span;
		int t;
		span = int'(ctl_cfg.hysteresis) + 40;
		if ($urandom_range(0, 99) < 15)
			return any_temp();
		t = set + int'($urandom_range(0, 2 * span)) - span;
		if (t < -880)
			t = -880;
		if (t > 2000)
			t = 2000;
		return 12'(t);
	endfunction

	function automatic void advance_clock(int unsigned span);
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			clock_ms += $urandom_range(0, span);
		else if (sel < 85)
			clock_ms += $urandom_range(span, 10 * span);
		else if (sel < 95)
			clock_ms += MS_PER_HOUR * $urandom_range(0, 2) + $urandom_range(0, 60000);
		else
			clock_ms = $urandom();
	endfunction

	function automatic logic [10:0] pick_hours();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			return 11'($urandom_range(0, 2));
		if (sel < 90)
			return 11'($urandom_range(3, 30));
		return 11'($urandom());
	endfunction

	function automatic logic [22:0] pick_run_seconds();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 80)
			return 23'($urandom_range(0, 3000));
		if (sel < 90)
			return 23'($urandom_range(0, 4294967));
		return 23'($urandom());
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.kind = 3'($urandom_range(0, 7));
		it.now_ms = ($urandom_range(0, 99) < 20) ? $urandom() : clock_ms;
		it.temperature = any_temp();
		it.step_index = 4'($urandom());
		it.step_target = any_temp();
		it.step_hold_hours = 11'($urandom());
		it.step_count = 5'($urandom());
		it.run_seconds = 23'($urandom());
		return it;
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		if ($urandom_range(0, 9) == 0)
			c.hysteresis = 9'($urandom_range(0, 320));
		else
			c.hysteresis = 9'($urandom_range(0, 40));
		c.alarm_limit = 12'($urandom_range(300, 2000));
		c.pump_hold_after_heat = $urandom_range(0, 2000000);
		c.pump_run_time = $urandom_range(0, 600000);
		c.pump_rest_time = $urandom_range(0, 600000);
		c.filtration_setpoint = any_temp();
		return c;
	endfunction

	task automatic ferment_run();
		in_item_t it;
		int steps;
		int sel;
		steps = $urandom_range(1, 4);
		for (int i = 0; i < steps; i++) begin
			it = rand_item();
			it.kind = KIND_LOAD;
			it.step_index = 4'(i);
			it.step_target = 12'(int'($urandom_range(0, 1100)) - 300);
			it.step_hold_hours = pick_hours();
			send_item(it);
		end
		it = rand_item();
		it.kind = KIND_FERM;
		it.now_ms = clock_ms;
		if ($urandom_range(0, 99) < 70)
			it.step_count = 5'(steps);
		else
			it.step_count = 5'($urandom_range(1, 31));
		send_item(it);
		repeat ($urandom_range(5, 30)) begin
			sel = $urandom_range(0, 99);
			advance_clock(120000);
			it = rand_item();
			if (sel >= 8) begin
				it.kind = KIND_TICK;
				it.now_ms = clock_ms;
				it.temperature = temp_near(int'(st_setpoint));
			end else if (sel >= 5) begin
				it.kind = KIND_STOP;
			end
			send_item(it);
		end
		if ($urandom_range(0, 1) == 0) begin
			it = rand_item();
			it.kind = KIND_STOP;
			send_item(it);
		end
	endtask

	task automatic filter_run();
		in_item_t it;
		int sel;
		it = rand_item();
		it.kind = KIND_FILT;
		it.now_ms = clock_ms;
		it.run_seconds = pick_run_seconds();
		send_item(it);
		repeat ($urandom_range(5, 30)) begin
			sel = $urandom_range(0, 99);
			advance_clock(60000);
			it = rand_item();
			if (sel >= 8) begin
				it.kind = KIND_TICK;
				it.now_ms = clock_ms;
				it.temperature = temp_near(int'(ctl_cfg.filtration_setpoint));
			end else if (sel >= 5) begin
				it.kind = KIND_STOP;
			end
			send_item(it);
		end
	endtask

	task automatic random_sequence();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			ferment_run();
		else if (sel < 80)
			filter_run();
		else
			repeat ($urandom_range(1, 5)) send_item(rand_item());
	endtask

	task automatic run_traffic(int unsigned count);
		int unsigned goal;
		goal = items_sent + count;
		while (items_sent < goal)
			random_sequence();
	endtask

	task automatic test_directed();
		in_item_t it;
		for (int i = 0; i < MAX_STEPS; i++) begin
			it = rand_item();
			it.kind = KIND_LOAD;
			it.step_index = 4'(i);
			it.step_target = (i == 0) ? -12'sd880 : (i == 1) ? 12'sd2000 : any_temp();
			it.step_hold_hours = (i == 0) ? 11'd0 : (i == 1) ? 11'd2047 :
				(i == 2) ? 11'd1193 : 11'($urandom_range(0, 3));
			send_item(it);
		end
		// All fields at ones, which is also an unknown command.
		it = '1;
		send_item(it);
		it = rand_item();
		it.kind = KIND_STOP;
		send_item(it);
		it.kind = KIND_FERM;
		it.step_count = '0;
		send_item(it);
		it.step_count = '1;
		it.now_ms = 32'hFFFF_FF00;
		send_item(it);
		it = rand_item();
		it.kind = KIND_TICK;
		it.now_ms = 32'h0000_0100;
		it.temperature = -12'sd880;
		send_item(it);
		it.temperature = 12'sd2000;
		send_item(it);
		it.temperature = -12'sd880;
		send_item(it);
		it.kind = KIND_FILT;
		it.now_ms = '1;
		it.run_seconds = '1;
		send_item(it);
		it.kind = KIND_TICK;
		it.now_ms = '0;
		it.temperature = 12'sd1216;
		send_item(it);
		it.kind = KIND_STOP;
		send_item(it);
	endtask

	task automatic test_fermentation();
		int unsigned goal;
		drain_results();
		load_settings(random_settings());
		clock_ms = $urandom();
		goal = items_sent + 400;
		while (items_sent < goal)
			ferment_run();
	endtask

	task automatic test_filtration();
		int unsigned goal;
		drain_results();
		load_settings(random_settings());
		goal = items_sent + 300;
		while (items_sent < goal)
			filter_run();
	endtask

	task automatic test_extreme_settings();
		cfg_t c;
		c.hysteresis = 9'd0;
		c.alarm_limit = 12'sd2000;
		c.pump_hold_after_heat = '0;
		c.pump_run_time = '0;
		c.pump_rest_time = '0;
		c.filtration_setpoint = -12'sd880;
		drain_results();
		load_settings(c);
		run_traffic(150);
		c.hysteresis = 9'd320;
		c.alarm_limit = -12'sd880;
		c.pump_hold_after_heat = '1;
		c.pump_run_time = '1;
		c.pump_rest_time = '1;
		c.filtration_setpoint = 12'sd2000;
		drain_results();
		load_settings(c);
		run_traffic(150);
	endtask

	task automatic test_unbroken_flow();
		drain_results();
		load_settings(random_settings());
		idling = 1'b0;
		run_traffic(300);
		idling = 1'b1;
	endtask

	task automatic test_mixed_traffic();
		repeat (4) begin
			drain_results();
			load_settings(random_settings());
			run_traffic(60);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_wen <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		idling = 1'b1;
		error_count = 0;
		items_sent = 0;
		clock_ms = '0;
		reset_controller_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fermentation();
		test_filtration();
		test_extreme_settings();
		test_unbroken_flow();
		test_mixed_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

[ferment_filter_temperature_controller.f]
hdl/ffc_pkg.sv
hdl/ffc_ram.sv
hdl/ffc_profile.sv
hdl/ffc_core.sv
hdl/ferment_filter_temperature_controller.sv
verif/ferment_filter_temperature_controller_tb.sv
